FILE: sv/ssrg_pkg.sv
package ssrg_pkg;

  localparam int unsigned PERIOD_BITS = 32;
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned SPEED_BITS  = 16;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned SCALE_BITS  = 32;
  localparam int unsigned CFG_BITS    = 32;
  localparam int unsigned NUM_BITS    = SCALE_BITS + SAMPLE_BITS;
  localparam int unsigned DEN_BITS    = SPEED_BITS + SAMPLE_BITS + 1;
  localparam int unsigned ITER_BITS   = $clog2(NUM_BITS + 1);

  localparam logic [COUNT_BITS-1:0]  TICKS_PER_UPDATE_RST = COUNT_BITS'(2000);
  localparam logic [COUNT_BITS-1:0]  OFF_DELAY_RST        = COUNT_BITS'(100);
  localparam logic [SCALE_BITS-1:0]  PERIOD_SCALE_RST     = SCALE_BITS'(1000000);
  localparam logic [SPEED_BITS-1:0]  MIN_SPEED_RST        = SPEED_BITS'(10);
  localparam logic [SPEED_BITS-1:0]  MAX_SPEED_RST        = SPEED_BITS'(1000);
  localparam logic [SAMPLE_BITS-1:0] ADC_FULL_SCALE_RST   = SAMPLE_BITS'(1023);
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX           = '1;

  typedef enum logic [2:0] {
    CFG_TICKS_PER_UPDATE = 3'd0,
    CFG_OFF_DELAY        = 3'd1,
    CFG_PERIOD_SCALE     = 3'd2,
    CFG_MIN_SPEED        = 3'd3,
    CFG_MAX_SPEED        = 3'd4,
    CFG_ADC_FULL_SCALE   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MOT_STOP = 2'd0,
    MOT_FWD  = 2'd1,
    MOT_REV  = 2'd2
  } motion_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DENA,
    ST_MUL_DENB,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                   fwd_switch;
    logic                   rev_switch;
    logic [SAMPLE_BITS-1:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic step_pulse;
    logic direction;
    logic driver_enable;
    logic status_led;
  } out_word_t;

endpackage

FILE: sv/stepper_step_rate_generator.sv
// Step pulse generator for a stepper motor driver. Each input word is one timer tick
// carrying the two jog switches and the speed potentiometer sample, and each tick
// yields exactly one output word with the step pulse, direction, driver enable and
// status LED levels. A tick that does not fall on a control update is accepted and
// answered in the following cycle. On a control update, a shared 32 by 10 bit
// multiplier forms the numerator and then the two denominator terms, a restoring
// divider yields one quotient bit per cycle for all 42 bits, and the done state
// applies it when the output is free. The input is stalled while an update is in progress.
// Configuration registers may only be written while the block is idle.
module stepper_step_rate_generator import ssrg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_word_t                in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_word_t               out_word_o
);

  logic [COUNT_BITS-1:0]  ticks_per_update_q, off_delay_q;
  logic [SCALE_BITS-1:0]  period_scale_q;
  logic [SPEED_BITS-1:0]  min_speed_q, max_speed_q;
  logic [SAMPLE_BITS-1:0] adc_full_scale_q;

  state_e                 state_q, state_d;
  logic [COUNT_BITS-1:0]  tick_q, tick_d, idle_q, idle_d;
  logic [PERIOD_BITS-1:0] step_count_q, step_count_d, step_period_q, step_period_d;
  motion_e                motion_q, motion_d, prev_motion_q, prev_motion_d;
  logic                   drv_q, drv_d, dir_q, dir_d, led_q, led_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_word_q, out_word_d;

  logic                   fwd_q, fwd_d, rev_q, rev_d, pulse_q, pulse_d;
  logic [SAMPLE_BITS-1:0] samp_q, samp_d;
  logic [NUM_BITS-1:0]    quo_q, quo_d;
  logic [DEN_BITS-1:0]    den_q, den_d, rem_q, rem_d;
  logic [ITER_BITS-1:0]   iter_q, iter_d;

  logic                   accept, out_free, cnt_end, do_update;
  logic [COUNT_BITS-1:0]  tick_next, idle_inc;
  logic [SCALE_BITS-1:0]  mul_a;
  logic [SAMPLE_BITS-1:0] mul_b;
  logic [NUM_BITS-1:0]    mul_p;
  logic [DEN_BITS:0]      rem_shift;
  logic [PERIOD_BITS-1:0] period;
  motion_e                new_motion;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && !in_stall_o;
  assign tick_next = tick_q + COUNT_BITS'(1);
  assign do_update = (tick_next == ticks_per_update_q);
  assign cnt_end   = (step_count_q <= PERIOD_BITS'(1));

  assign mul_p     = mul_a * mul_b;
  assign rem_shift = {rem_q, quo_q[NUM_BITS-1]};
  assign idle_inc  = idle_q + COUNT_BITS'(1);

  always_comb begin
    mul_a = period_scale_q;
    mul_b = adc_full_scale_q;
    case (state_q)
      ST_MUL_DENA: begin
        mul_a = SCALE_BITS'(min_speed_q);
        mul_b = adc_full_scale_q;
      end
      ST_MUL_DENB: begin
        mul_a = SCALE_BITS'(max_speed_q);
        mul_b = samp_q;
      end
      default: begin
        mul_a = period_scale_q;
        mul_b = adc_full_scale_q;
      end
    endcase
  end

  always_comb begin
    if (den_q == '0) begin
      period = PERIOD_MAX;
    end else if (|quo_q[NUM_BITS-1:PERIOD_BITS]) begin
      period = PERIOD_MAX;
    end else if (quo_q == '0) begin
      period = PERIOD_BITS'(1);
    end else begin
      period = quo_q[PERIOD_BITS-1:0];
    end
    if (fwd_q) begin
      new_motion = MOT_FWD;
    end else if (rev_q) begin
      new_motion = MOT_REV;
    end else begin
      new_motion = MOT_STOP;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && do_update) begin
          state_d = ST_MUL_NUM;
        end
      end
      ST_MUL_NUM:  state_d = ST_MUL_DENA;
      ST_MUL_DENA: state_d = ST_MUL_DENB;
      ST_MUL_DENB: state_d = ST_DIV;
      ST_DIV: begin
        if (iter_q == ITER_BITS'(NUM_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = !((state_q == ST_IDLE) && out_free);
    tick_d        = tick_q;
    idle_d        = idle_q;
    step_count_d  = step_count_q;
    step_period_d = step_period_q;
    motion_d      = motion_q;
    prev_motion_d = prev_motion_q;
    drv_d         = drv_q;
    dir_d         = dir_q;
    led_d         = led_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_word_d    = out_word_q;
    fwd_d         = fwd_q;
    rev_d         = rev_q;
    pulse_d       = pulse_q;
    samp_d        = samp_q;
    quo_d         = quo_q;
    den_d         = den_q;
    rem_d         = rem_q;
    iter_d        = iter_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pulse_d      = cnt_end && (motion_q != MOT_STOP);
          step_count_d = cnt_end ? step_period_q : step_count_q - PERIOD_BITS'(1);
          fwd_d        = in_word_i.fwd_switch;
          rev_d        = in_word_i.rev_switch;
          samp_d       = (in_word_i.adc_sample > adc_full_scale_q) ?
                         adc_full_scale_q : in_word_i.adc_sample;
          if (do_update) begin
            tick_d = '0;
          end else begin
            tick_d                   = tick_next;
            out_valid_d              = 1'b1;
            out_word_d.step_pulse    = cnt_end && (motion_q != MOT_STOP);
            out_word_d.direction     = dir_q;
            out_word_d.driver_enable = drv_q;
            out_word_d.status_led    = led_q;
          end
        end
      end
      ST_MUL_NUM: begin
        quo_d = mul_p;
      end
      ST_MUL_DENA: begin
        den_d = DEN_BITS'(mul_p);
      end
      ST_MUL_DENB: begin
        den_d  = den_q + DEN_BITS'(mul_p);
        rem_d  = '0;
        iter_d = '0;
      end
      ST_DIV: begin
        iter_d = iter_q + ITER_BITS'(1);
        if (rem_shift >= {1'b0, den_q}) begin
          rem_d = DEN_BITS'(rem_shift - {1'b0, den_q});
          quo_d = {quo_q[NUM_BITS-2:0], 1'b1};
        end else begin
          rem_d = rem_shift[DEN_BITS-1:0];
          quo_d = {quo_q[NUM_BITS-2:0], 1'b0};
        end
      end
      ST_DONE: begin
        if (out_free) begin
          step_period_d = period;
          motion_d      = new_motion;
          prev_motion_d = new_motion;
          if (new_motion == MOT_FWD) begin
            dir_d = 1'b1;
          end else if (new_motion == MOT_REV) begin
            dir_d = 1'b0;
          end
          if (new_motion != MOT_STOP) begin
            led_d  = 1'b1;
            drv_d  = 1'b1;
            idle_d = '0;
            if (new_motion != prev_motion_q) begin
              step_count_d = period;
            end
          end else begin
            led_d  = 1'b0;
            idle_d = idle_inc;
            if (idle_inc >= off_delay_q) begin
              drv_d  = 1'b0;
              idle_d = off_delay_q;
            end
          end
          out_valid_d              = 1'b1;
          out_word_d.step_pulse    = pulse_q;
          out_word_d.direction     = dir_d;
          out_word_d.driver_enable = drv_d;
          out_word_d.status_led    = led_d;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_update_q <= TICKS_PER_UPDATE_RST;
      off_delay_q        <= OFF_DELAY_RST;
      period_scale_q     <= PERIOD_SCALE_RST;
      min_speed_q        <= MIN_SPEED_RST;
      max_speed_q        <= MAX_SPEED_RST;
      adc_full_scale_q   <= ADC_FULL_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TICKS_PER_UPDATE: ticks_per_update_q <= cfg_wdata_i[COUNT_BITS-1:0];
        CFG_OFF_DELAY:        off_delay_q        <= cfg_wdata_i[COUNT_BITS-1:0];
        CFG_PERIOD_SCALE:     period_scale_q     <= cfg_wdata_i[SCALE_BITS-1:0];
        CFG_MIN_SPEED:        min_speed_q        <= cfg_wdata_i[SPEED_BITS-1:0];
        CFG_MAX_SPEED:        max_speed_q        <= cfg_wdata_i[SPEED_BITS-1:0];
        CFG_ADC_FULL_SCALE:   adc_full_scale_q   <= cfg_wdata_i[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tick_q        <= '0;
      idle_q        <= '0;
      step_count_q  <= '0;
      step_period_q <= '0;
      motion_q      <= MOT_STOP;
      prev_motion_q <= MOT_STOP;
      drv_q         <= 1'b0;
      dir_q         <= 1'b0;
      led_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      iter_q        <= '0;
    end else begin
      state_q       <= state_d;
      tick_q        <= tick_d;
      idle_q        <= idle_d;
      step_count_q  <= step_count_d;
      step_period_q <= step_period_d;
      motion_q      <= motion_d;
      prev_motion_q <= prev_motion_d;
      drv_q         <= drv_d;
      dir_q         <= dir_d;
      led_q         <= led_d;
      out_valid_q   <= out_valid_d;
      iter_q        <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    fwd_q      <= fwd_d;
    rev_q      <= rev_d;
    pulse_q    <= pulse_d;
    samp_q     <= samp_d;
    quo_q      <= quo_d;
    den_q      <= den_d;
    rem_q      <= rem_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
